// File: hdl/fca_pkg.sv
package fca_pkg;

	// table geometry
	localparam int MAX_ENTRIES = 8192;
	localparam int ADDR_W = $clog2(MAX_ENTRIES);
	localparam int CNT_W = 14;
	localparam int IDX_W = 16;
	localparam int STEP_W = 13;
	localparam logic [IDX_W-1:0] FAT_EOC = 16'hFFFF;
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);
	localparam logic [CNT_W-1:0] CFG_RESET = 14'd8192;

	// operation codes
	typedef enum logic [2:0] {
		OP_ALLOC = 3'd0,
		OP_FREE  = 3'd1,
		OP_WALK  = 3'd2,
		OP_WRITE = 3'd3,
		OP_READ  = 3'd4
	} op_t;

	// result status codes
	typedef enum logic [1:0] {
		STS_OK    = 2'd0,
		STS_FULL  = 2'd1,
		STS_RANGE = 2'd2,
		STS_EARLY = 2'd3
	} status_t;

	// one request
	typedef struct packed {
		logic [2:0]        operation;
		logic [IDX_W-1:0]  index;
		logic [IDX_W-1:0]  tail_index;
		logic [IDX_W-1:0]  entry_value;
		logic [STEP_W-1:0] steps;
	} req_t;

	// one result
	typedef struct packed {
		logic [1:0]       status;
		logic [IDX_W-1:0] block_index;
		logic [IDX_W-1:0] read_value;
		logic [CNT_W-1:0] used_count;
	} res_t;

	// table access from the sequencer
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [IDX_W-1:0]  wdata;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

	// index names a data block: 1 .. count-1
	function automatic logic is_block(input logic [IDX_W-1:0] i, input logic [CNT_W-1:0] n);
		return (i != '0) && (i < IDX_W'(n));
	endfunction

endpackage

// File: hdl/fat_chain_allocator.sv
// File allocation table manager: 8192 16-bit entries (0 free, 0xFFFF end of chain) plus a
// used-entry count. One transaction at a time: s_axis_tready is high only while the
// sequencer is idle. After reset the table is swept to zero, one entry per cycle through
// its single write port, so no input is taken until the sweep is done. Requests out of
// range are rejected before any table access. Read and write entry read the entry, then
// return it or write it; allocate scans entries up to and including the first free one,
// then links a tail when one is given; free chain reads then clears each entry on the one
// table port; walk follows links until the step count, the chain end or a break. A result
// leaves the sequencer only once the output register is free. A finished result waits in
// the output register, and the next transaction can be taken while it waits.
module fat_chain_allocator
	import fca_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// operation[2:0], index[18:3], tail_index[34:19], entry_value[50:35], steps[63:51]
	input  logic [63:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// status[1:0], block_index[17:2], read_value[33:18], used_count[47:34]
	output logic [47:0] m_axis_tdata,
	input  logic        cfg_we,
	input  logic [13:0] cfg_data
);

	logic [CNT_W-1:0]  cfg_q;
	logic [CNT_W-1:0]  count;
	logic              busy;
	logic              idle;
	logic              start;
	logic              done;
	logic              out_vld_q;
	logic              out_free;
	res_t              res;
	res_t              out_q;
	req_t              req;
	mem_req_t          mem_req;
	logic [IDX_W-1:0]  rd_data;

	// block count register, limited to the table depth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			cfg_q <= cfg_data;
		end
	end

	assign count = (cfg_q > MAX_CNT) ? MAX_CNT : cfg_q;

	// input unpacking and handshake
	assign req.operation = s_axis_tdata[2:0];
	assign req.index = s_axis_tdata[18:3];
	assign req.tail_index = s_axis_tdata[34:19];
	assign req.entry_value = s_axis_tdata[50:35];
	assign req.steps = s_axis_tdata[63:51];
	assign s_axis_tready = idle && !busy;
	assign start = s_axis_tvalid && s_axis_tready;

	// output register
	assign out_free = !out_vld_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (done) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata = {out_q.used_count, out_q.read_value, out_q.block_index,
		out_q.status};

	fca_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.count    (count),
		.start    (start),
		.req      (req),
		.idle     (idle),
		.out_free (out_free),
		.done     (done),
		.res      (res),
		.mem_req  (mem_req),
		.rd_data  (rd_data)
	);

	fca_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.mem_req (mem_req),
		.rd_data (rd_data),
		.busy    (busy)
	);

endmodule

// File: hdl/fca_table.sv
module fca_table
	import fca_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  mem_req_t         mem_req,
	output logic [IDX_W-1:0] rd_data,
	output logic             busy
);

	logic [IDX_W-1:0]  mem [MAX_ENTRIES];
	logic [ADDR_W-1:0] clr_addr_q;
	logic              clr_q;

	// clearing sweep after reset, one entry per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			clr_q <= 1'b1;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == ADDR_W'(MAX_ENTRIES - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	// single write port, registered read port
	always_ff @(posedge clk) begin
		if (clr_q) begin
			mem[clr_addr_q] <= '0;
		end else if (mem_req.we) begin
			mem[mem_req.waddr] <= mem_req.wdata;
		end
		rd_data <= mem[mem_req.raddr];
	end

	assign busy = clr_q;

endmodule

// File: hdl/fca_ctrl.sv
module fca_ctrl
	import fca_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [CNT_W-1:0] count,
	input  logic             start,
	input  req_t             req,
	output logic             idle,
	input  logic             out_free,
	output logic             done,
	output res_t             res,
	output mem_req_t         mem_req,
	input  logic [IDX_W-1:0] rd_data
);

	typedef enum logic [10:0] {
		S_IDLE      = 11'b00000000001,
		S_DISPATCH  = 11'b00000000010,
		S_SCAN      = 11'b00000000100,
		S_ALLOC_WR  = 11'b00000001000,
		S_TAIL_RD   = 11'b00000010000,
		S_TAIL_WR   = 11'b00000100000,
		S_FREE_RD   = 11'b00001000000,
		S_FREE_WR   = 11'b00010000000,
		S_WALK      = 11'b00100000000,
		S_ENTRY_WR  = 11'b01000000000,
		S_DONE      = 11'b10000000000
	} state_t;

	state_t            state_q, state_d;
	req_t              req_q;
	logic [IDX_W-1:0]  cur_q, cur_d;
	logic [STEP_W-1:0] k_q, k_d;
	logic [CNT_W-1:0]  scan_q, scan_d;
	logic [ADDR_W-1:0] look_q, look_d;
	logic              look_vld_q, look_vld_d;
	logic [ADDR_W-1:0] found_q, found_d;
	logic [CNT_W-1:0]  used_q, used_d;
	logic              read_op_q, read_op_d;
	logic [1:0]        sts_q, sts_d;
	logic [IDX_W-1:0]  blk_q, blk_d;
	logic [IDX_W-1:0]  rdv_q, rdv_d;
	logic [STEP_W-1:0] k_inc;

	function automatic logic [CNT_W-1:0] cnt_up(input logic [CNT_W-1:0] u,
		input logic [CNT_W-1:0] n);
		return (u < n) ? u + 1'b1 : u;
	endfunction

	function automatic logic [CNT_W-1:0] cnt_down(input logic [CNT_W-1:0] u);
		return (u != '0) ? u - 1'b1 : u;
	endfunction

	assign k_inc = k_q + 1'b1;

	// sequencer: next state, table access and bookkeeping
	always_comb begin
		state_d = state_q;
		cur_d = cur_q;
		k_d = k_q;
		scan_d = scan_q;
		look_d = look_q;
		look_vld_d = look_vld_q;
		found_d = found_q;
		used_d = used_q;
		read_op_d = read_op_q;
		sts_d = sts_q;
		blk_d = blk_q;
		rdv_d = rdv_q;
		mem_req = '0;
		done = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				sts_d = STS_OK;
				blk_d = '0;
				rdv_d = '0;
				read_op_d = 1'b0;
				state_d = S_DONE;
				unique case (req_q.operation)
					OP_ALLOC: begin
						if (req_q.tail_index != FAT_EOC && !is_block(req_q.tail_index, count)) begin
							sts_d = STS_RANGE;
						end else if (used_q >= count) begin
							sts_d = STS_FULL;
						end else begin
							scan_d = CNT_W'(1);
							look_vld_d = 1'b0;
							state_d = S_SCAN;
						end
					end
					OP_FREE: begin
						if (!is_block(req_q.index, count)) begin
							sts_d = STS_RANGE;
						end else begin
							cur_d = req_q.index;
							state_d = S_FREE_RD;
						end
					end
					OP_WALK: begin
						if (!is_block(req_q.index, count)) begin
							sts_d = STS_RANGE;
						end else if (req_q.steps == '0) begin
							blk_d = req_q.index;
						end else begin
							mem_req.raddr = req_q.index[ADDR_W-1:0];
							cur_d = req_q.index;
							k_d = '0;
							state_d = S_WALK;
						end
					end
					OP_WRITE: begin
						if (!is_block(req_q.index, count)) begin
							sts_d = STS_RANGE;
						end else begin
							mem_req.raddr = req_q.index[ADDR_W-1:0];
							state_d = S_ENTRY_WR;
						end
					end
					OP_READ: begin
						if (req_q.index >= IDX_W'(count)) begin
							sts_d = STS_RANGE;
						end else begin
							mem_req.raddr = req_q.index[ADDR_W-1:0];
							read_op_d = 1'b1;
						end
					end
					default: begin
						sts_d = STS_RANGE;
					end
				endcase
			end
			// one entry issued per cycle, checked in the cycle after
			S_SCAN: begin
				if (look_vld_q && rd_data == '0) begin
					found_d = look_q;
					state_d = S_ALLOC_WR;
				end else if (scan_q < count) begin
					mem_req.raddr = scan_q[ADDR_W-1:0];
					look_d = scan_q[ADDR_W-1:0];
					look_vld_d = 1'b1;
					scan_d = scan_q + 1'b1;
				end else begin
					look_vld_d = 1'b0;
					if (!look_vld_q) begin
						sts_d = STS_FULL;
						state_d = S_DONE;
					end
				end
			end
			S_ALLOC_WR: begin
				mem_req.we = 1'b1;
				mem_req.waddr = found_q;
				mem_req.wdata = FAT_EOC;
				used_d = cnt_up(used_q, count);
				blk_d = IDX_W'(found_q);
				if (req_q.tail_index == FAT_EOC) begin
					state_d = S_DONE;
				end else begin
					state_d = S_TAIL_RD;
				end
			end
			// tail read after the new entry is written, it may be the same entry
			S_TAIL_RD: begin
				mem_req.raddr = req_q.tail_index[ADDR_W-1:0];
				state_d = S_TAIL_WR;
			end
			S_TAIL_WR: begin
				mem_req.we = 1'b1;
				mem_req.waddr = req_q.tail_index[ADDR_W-1:0];
				mem_req.wdata = IDX_W'(found_q);
				if (rd_data == '0) begin
					used_d = cnt_up(used_q, count);
				end
				state_d = S_DONE;
			end
			S_FREE_RD: begin
				mem_req.raddr = cur_q[ADDR_W-1:0];
				state_d = S_FREE_WR;
			end
			S_FREE_WR: begin
				mem_req.we = 1'b1;
				mem_req.waddr = cur_q[ADDR_W-1:0];
				mem_req.wdata = '0;
				if (rd_data != '0) begin
					used_d = cnt_down(used_q);
				end
				if (rd_data == FAT_EOC) begin
					state_d = S_DONE;
				end else if (!is_block(rd_data, count)) begin
					sts_d = STS_RANGE;
					state_d = S_DONE;
				end else begin
					cur_d = rd_data;
					state_d = S_FREE_RD;
				end
			end
			// one link per cycle, next read issued from the link just read
			S_WALK: begin
				if (rd_data == FAT_EOC) begin
					sts_d = STS_EARLY;
					blk_d = cur_q;
					state_d = S_DONE;
				end else if (!is_block(rd_data, count)) begin
					sts_d = STS_RANGE;
					state_d = S_DONE;
				end else begin
					cur_d = rd_data;
					k_d = k_inc;
					if (k_inc == req_q.steps) begin
						blk_d = rd_data;
						state_d = S_DONE;
					end else begin
						mem_req.raddr = rd_data[ADDR_W-1:0];
					end
				end
			end
			S_ENTRY_WR: begin
				mem_req.we = 1'b1;
				mem_req.waddr = req_q.index[ADDR_W-1:0];
				mem_req.wdata = req_q.entry_value;
				if (rd_data == '0 && req_q.entry_value != '0) begin
					used_d = cnt_up(used_q, count);
				end else if (rd_data != '0 && req_q.entry_value == '0) begin
					used_d = cnt_down(used_q);
				end
				state_d = S_DONE;
			end
			S_DONE: begin
				if (read_op_q) begin
					rdv_d = rd_data;
					read_op_d = 1'b0;
				end
				if (out_free && !read_op_q) begin
					done = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			used_q <= CNT_W'(1);
			look_vld_q <= 1'b0;
			read_op_q <= 1'b0;
		end else begin
			state_q <= state_d;
			used_q <= used_d;
			look_vld_q <= look_vld_d;
			read_op_q <= read_op_d;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (start && state_q == S_IDLE) begin
			req_q <= req;
		end
		cur_q <= cur_d;
		k_q <= k_d;
		scan_q <= scan_d;
		look_q <= look_d;
		found_q <= found_d;
		sts_q <= sts_d;
		blk_q <= blk_d;
		rdv_q <= rdv_d;
	end

	assign idle = (state_q == S_IDLE);
	assign res.status = sts_q;
	assign res.block_index = blk_q;
	assign res.read_value = rdv_q;
	assign res.used_count = used_q;

endmodule
